// ----- hw/rtl/ale_pkg.sv -----
// ----------------------------------------------------------------------------
// Array list engine package
// Operation codes, status codes, sequencer states and the per-cell control
// group shared by the engine, its cells and its checker.
// ----------------------------------------------------------------------------
package ale_pkg;

   typedef enum logic [2:0] {
      MODE_APPEND = 3'd0,
      MODE_INSERT = 3'd1,
      MODE_DELETE = 3'd2,
      MODE_COUNT  = 3'd3,
      MODE_MIN    = 3'd4,
      MODE_READ   = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_RANGE   = 3'd2,
      ST_MISSING = 3'd3,
      ST_EMPTY   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_APPLY
   } state_type;

   typedef struct packed {
      logic write_value;
      logic take_left;
      logic take_right;
   } cell_ctl_type;

endpackage

// ----- hw/rtl/ale_cell.sv -----
// ----------------------------------------------------------------------------
// Array list cell
// Holds one list entry. Each cycle it folds its entry into the match count,
// first-match flag, running minimum and read word coming from the previous
// cell and registers them for the next cell. On an update it loads the
// request word or takes the entry of its left or right neighbor.
// ----------------------------------------------------------------------------
module ale_cell #(
   parameter int POS       = 0,
   parameter int CAPACITY  = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                                 clock,
   input  ale_pkg::cell_ctl_type                ctl,
   input  logic [WORD_BITS-1:0]                 word,
   input  logic [$clog2(CAPACITY+1)-1:0]        idx,
   input  logic [$clog2(CAPACITY+1)-1:0]        count,
   input  logic [WORD_BITS-1:0]                 left_entry,
   input  logic [WORD_BITS-1:0]                 right_entry,
   output logic [WORD_BITS-1:0]                 entry,
   input  logic [$clog2(CAPACITY+1)-1:0]        cnt_i,
   input  logic                                 found_i,
   input  logic                                 has_i,
   input  logic [WORD_BITS-1:0]                 min_i,
   input  logic [WORD_BITS-1:0]                 rd_i,
   output logic [$clog2(CAPACITY+1)-1:0]        cnt_o,
   output logic                                 found_o,
   output logic                                 has_o,
   output logic [WORD_BITS-1:0]                 min_o,
   output logic [WORD_BITS-1:0]                 rd_o
);

   localparam int CNT_W = $clog2(CAPACITY+1);

   logic [WORD_BITS-1:0] entry_ff, entry_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 found_ff, found_in;
   logic                 has_ff, has_in;
   logic [WORD_BITS-1:0] min_ff, min_in;
   logic [WORD_BITS-1:0] rd_ff, rd_in;
   logic                 valid;
   logic                 eq;
   logic                 hit;

   always_comb begin
      valid    = CNT_W'(POS) < count;
      eq       = valid && (entry_ff == word);
      hit      = valid && (idx == CNT_W'(POS));
      cnt_in   = cnt_i + CNT_W'(eq);
      found_in = found_i | eq;
      has_in   = has_i | valid;
      if (valid && (!has_i || ($signed(entry_ff) < $signed(min_i)))) begin
         min_in = entry_ff;
      end else begin
         min_in = min_i;
      end
      rd_in = hit ? entry_ff : rd_i;

      if (ctl.write_value) begin
         entry_in = word;
      end else if (ctl.take_left) begin
         entry_in = left_entry;
      end else if (ctl.take_right) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      cnt_ff   <= cnt_in;
      found_ff <= found_in;
      has_ff   <= has_in;
      min_ff   <= min_in;
      rd_ff    <= rd_in;
   end

   assign entry   = entry_ff;
   assign cnt_o   = cnt_ff;
   assign found_o = found_ff;
   assign has_o   = has_ff;
   assign min_o   = min_ff;
   assign rd_o    = rd_ff;

endmodule

// ----- hw/rtl/array_list_engine.sv -----
// A request is taken only while the engine is idle, and the next one waits
// until it is answered; the scan results ripple through the row of cells
// one cell per cycle before the list is updated.
// A finished response waits in the output register while the next request
// is taken. Reset empties the list and drops any pending response; the
// entries themselves are not cleared.
// ----------------------------------------------------------------------------
// Array list engine
// Fixed-capacity ordered list of signed words held in a row of cells, with
// append, insert, delete, count, minimum and read operations.
// ----------------------------------------------------------------------------
module array_list_engine #(
   parameter int CAPACITY  = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_mode,
   input  logic [$clog2(CAPACITY+1)-1:0]     req_index,
   input  logic [WORD_BITS-1:0]              req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [2:0]                        rsp_status,
   output logic [$clog2(CAPACITY+1)-1:0]     rsp_live_size,
   output logic [$clog2(CAPACITY+1)-1:0]     rsp_match_count,
   output logic [WORD_BITS-1:0]              rsp_data_word
);

   localparam int CNT_W  = $clog2(CAPACITY+1);
   localparam int SCAN_W = $clog2(CAPACITY);

   ale_pkg::state_type   state_ff, state_in;
   logic [SCAN_W-1:0]    scan_ff, scan_in;
   logic [2:0]           mode_ff, mode_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [WORD_BITS-1:0] value_ff, value_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           status_ff, status_in;
   logic [CNT_W-1:0]     size_ff, size_in;
   logic [CNT_W-1:0]     match_ff, match_in;
   logic [WORD_BITS-1:0] data_ff, data_in;

   logic [WORD_BITS-1:0] ent [CAPACITY];
   logic [CNT_W-1:0]     cnt_w [CAPACITY+1];
   logic                 found_w [CAPACITY+1];
   logic                 has_w [CAPACITY+1];
   logic [WORD_BITS-1:0] min_w [CAPACITY+1];
   logic [WORD_BITS-1:0] rd_w [CAPACITY+1];
   ale_pkg::cell_ctl_type ctl [CAPACITY];

   logic commit;
   logic full;
   logic add_ok;
   logic ins_ok;
   logic del_ok;

   assign cnt_w[0]   = '0;
   assign found_w[0] = 1'b0;
   assign has_w[0]   = 1'b0;
   assign min_w[0]   = '0;
   assign rd_w[0]    = '0;

   for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
      ale_cell #(
         .POS       (j),
         .CAPACITY  (CAPACITY),
         .WORD_BITS (WORD_BITS)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl[j]),
         .word        (value_ff),
         .idx         (idx_ff),
         .count       (count_ff),
         .left_entry  (ent[(j == 0) ? 0 : j - 1]),
         .right_entry (ent[(j == CAPACITY - 1) ? j : j + 1]),
         .entry       (ent[j]),
         .cnt_i       (cnt_w[j]),
         .found_i     (found_w[j]),
         .has_i       (has_w[j]),
         .min_i       (min_w[j]),
         .rd_i        (rd_w[j]),
         .cnt_o       (cnt_w[j+1]),
         .found_o     (found_w[j+1]),
         .has_o       (has_w[j+1]),
         .min_o       (min_w[j+1]),
         .rd_o        (rd_w[j+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ale_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff   <= scan_in;
      mode_ff   <= mode_in;
      idx_ff    <= idx_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      size_ff   <= size_in;
      match_ff  <= match_in;
      data_ff   <= data_in;
   end

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      mode_in      = mode_ff;
      idx_in       = idx_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      size_in      = size_ff;
      match_in     = match_ff;
      data_in      = data_ff;
      req_ready    = 1'b0;
      commit       = 1'b0;

      full   = count_ff == CNT_W'(CAPACITY);
      add_ok = (ale_pkg::mode_type'(mode_ff) == ale_pkg::MODE_APPEND) && !full;
      ins_ok = (ale_pkg::mode_type'(mode_ff) == ale_pkg::MODE_INSERT) && !full
               && (idx_ff <= count_ff);
      del_ok = (ale_pkg::mode_type'(mode_ff) == ale_pkg::MODE_DELETE)
               && found_w[CAPACITY];

      case (state_ff)
         ale_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in  = req_mode;
               idx_in   = req_index;
               value_in = req_value;
               scan_in  = '0;
               state_in = ale_pkg::S_SCAN;
            end
         end
         ale_pkg::S_SCAN: begin
            scan_in = scan_ff + SCAN_W'(1);
            if (scan_ff == SCAN_W'(CAPACITY - 1)) begin
               state_in = ale_pkg::S_APPLY;
            end
         end
         ale_pkg::S_APPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               commit       = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ale_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ale_pkg::S_IDLE;
         end
      endcase

      if (commit) begin
         status_in = ale_pkg::ST_OK;
         match_in  = '0;
         data_in   = '0;
         case (ale_pkg::mode_type'(mode_ff))
            ale_pkg::MODE_APPEND, ale_pkg::MODE_INSERT: begin
               if (full) begin
                  status_in = ale_pkg::ST_FULL;
               end else if (!add_ok && !ins_ok) begin
                  status_in = ale_pkg::ST_RANGE;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            ale_pkg::MODE_DELETE: begin
               if (del_ok) begin
                  count_in = count_ff - CNT_W'(1);
               end else begin
                  status_in = ale_pkg::ST_MISSING;
               end
            end
            ale_pkg::MODE_COUNT: begin
               match_in = cnt_w[CAPACITY];
            end
            ale_pkg::MODE_MIN: begin
               if (count_ff == '0) begin
                  status_in = ale_pkg::ST_EMPTY;
               end else begin
                  data_in = min_w[CAPACITY];
               end
            end
            ale_pkg::MODE_READ: begin
               if (idx_ff >= count_ff) begin
                  status_in = ale_pkg::ST_RANGE;
               end else begin
                  data_in = rd_w[CAPACITY];
               end
            end
            default: begin
               status_in = ale_pkg::ST_OK;
            end
         endcase
         size_in = count_in;
      end
   end

   always_comb begin
      for (int j = 0; j < CAPACITY; j++) begin
         ctl[j].write_value = commit
                              && ((add_ok && (CNT_W'(j) == count_ff))
                              || (ins_ok && (CNT_W'(j) == idx_ff)));
         ctl[j].take_left   = commit && ins_ok && (CNT_W'(j) > idx_ff);
         ctl[j].take_right  = commit && del_ok && found_w[j+1];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_live_size   = size_ff;
   assign rsp_match_count = match_ff;
   assign rsp_data_word   = data_ff;

endmodule

// ----- hw/rtl/ale_checker.sv -----
// ----------------------------------------------------------------------------
// Array list engine checker
// Watches the ports of the engine and flags responses and handshakes that
// the list logic can never produce.
// ----------------------------------------------------------------------------
module ale_checker #(
   parameter int CAPACITY  = 16,
   parameter int WORD_BITS = 32
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [2:0]                        req_mode,
   input logic [$clog2(CAPACITY+1)-1:0]     req_index,
   input logic [WORD_BITS-1:0]              req_value,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [2:0]                        rsp_status,
   input logic [$clog2(CAPACITY+1)-1:0]     rsp_live_size,
   input logic [$clog2(CAPACITY+1)-1:0]     rsp_match_count,
   input logic [WORD_BITS-1:0]              rsp_data_word
);

   localparam int CNT_W = $clog2(CAPACITY+1);

   // The engine works on one request at a time.
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while the engine is busy");

   a_size_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_live_size <= CNT_W'(CAPACITY)))
      else $error("live size beyond capacity");

   // Only a count operation reports matches, and it never reports a data word.
   a_match_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_match_count != '0)) |->
         ((rsp_data_word == '0) && (rsp_status == ale_pkg::ST_OK)))
      else $error("match count reported with data or error status");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
         && $stable(rsp_live_size) && $stable(rsp_data_word)))
      else $error("stalled response changed");

endmodule

bind array_list_engine ale_checker #(
   .CAPACITY  (CAPACITY),
   .WORD_BITS (WORD_BITS)
) u_ale_checker (.*);

// ----- verif/array_list_engine_tb.sv -----
// ----------------------------------------------------------------------------
// Array list engine testbench
// Drives list operations over the request channel and checks every response
// against a behavioral copy of the list kept in the testbench. Directed
// requests cover the empty list, the field extremes and every operation. A
// fill and drain pass covers the full list. Random traffic then wanders
// between the empty and the full list under changing amounts of idling on
// both channels.
// ----------------------------------------------------------------------------
module array_list_engine_tb;

   localparam int CAPACITY    = 16;
   localparam int WORD_BITS   = 32;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_WAIT  = 2 * CAPACITY + 8;

   localparam logic [2:0] MODE_SPARE_LO = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   typedef struct {
      logic [2:0]           status;
      logic [4:0]           live_size;
      logic [4:0]           match_count;
      logic [WORD_BITS-1:0] data_word;
   } list_result_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [2:0]           req_mode;
   logic [4:0]           req_index;
   logic [WORD_BITS-1:0] req_value;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [2:0]           rsp_status;
   logic [4:0]           rsp_live_size;
   logic [4:0]           rsp_match_count;
   logic [WORD_BITS-1:0] rsp_data_word;

   logic [WORD_BITS-1:0] list_words [CAPACITY];
   int                   list_count;
   list_result_type      pending_results [$];
   int                   error_count;
   int                   cycle_count;
   int                   send_idle_pct;
   int                   rsp_stall_pct;
   bit                   list_growing;

   array_list_engine #(
      .CAPACITY  (CAPACITY),
      .WORD_BITS (WORD_BITS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_index       (req_index),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_live_size   (rsp_live_size),
      .rsp_match_count (rsp_match_count),
      .rsp_data_word   (rsp_data_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic list_result_type apply_list_op(logic [2:0] mode, logic [4:0] index,
                                                     logic [WORD_BITS-1:0] value);
      list_result_type r;
      int              i;
      int              pos;
      r.status      = ale_pkg::ST_OK;
      r.match_count = '0;
      r.data_word   = '0;
      case (mode)
         ale_pkg::MODE_APPEND: begin
            if (list_count >= CAPACITY) begin
               r.status = ale_pkg::ST_FULL;
            end else begin
               list_words[list_count] = value;
               list_count++;
            end
         end
         ale_pkg::MODE_INSERT: begin
            if (list_count >= CAPACITY) begin
               r.status = ale_pkg::ST_FULL;
            end else if (index > list_count) begin
               r.status = ale_pkg::ST_RANGE;
            end else begin
               for (i = list_count; i > index; i--) list_words[i] = list_words[i-1];
               list_words[index] = value;
               list_count++;
            end
         end
         ale_pkg::MODE_DELETE: begin
            pos = list_count;
            for (i = list_count - 1; i >= 0; i--) if (list_words[i] == value) pos = i;
            if (pos == list_count) begin
               r.status = ale_pkg::ST_MISSING;
            end else begin
               for (i = pos; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
               list_count--;
            end
         end
         ale_pkg::MODE_COUNT: begin
            for (i = 0; i < list_count; i++) if (list_words[i] == value) r.match_count++;
         end
         ale_pkg::MODE_MIN: begin
            if (list_count == 0) begin
               r.status = ale_pkg::ST_EMPTY;
            end else begin
               r.data_word = list_words[0];
               for (i = 1; i < list_count; i++)
                  if ($signed(list_words[i]) < $signed(r.data_word)) r.data_word = list_words[i];
            end
         end
         ale_pkg::MODE_READ: begin
            if (index >= list_count) r.status = ale_pkg::ST_RANGE;
            else r.data_word = list_words[index];
         end
         default: begin
         end
      endcase
      r.live_size = list_count[4:0];
      return r;
   endfunction

   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: response with no request pending, status %0d size %0d",
                     $time, rsp_status, rsp_live_size);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_live_size !== want.live_size) begin
               $display("%0t: live_size expected %0d actual %0d",
                        $time, want.live_size, rsp_live_size);
               error_count++;
            end
            if (rsp_match_count !== want.match_count) begin
               $display("%0t: match_count expected %0d actual %0d",
                        $time, want.match_count, rsp_match_count);
               error_count++;
            end
            if (rsp_data_word !== want.data_word) begin
               $display("%0t: data_word expected %h actual %h",
                        $time, want.data_word, rsp_data_word);
               error_count++;
            end
         end
      end
   end

   task automatic send_request(logic [2:0] mode, logic [4:0] index, logic [WORD_BITS-1:0] value);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_index <= index;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(apply_list_op(mode, index, value));
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [WORD_BITS-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 45) return WORD_BITS'($urandom_range(7)) - WORD_BITS'(4);
      if (r < 60) begin
         case ($urandom_range(4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'h8000_0001;
         endcase
      end
      if (r < 80 && list_count > 0) return list_words[$urandom_range(list_count - 1)];
      return $urandom();
   endfunction

   function automatic logic [4:0] pick_index();
      if ($urandom_range(99) < 80) return 5'($urandom_range(list_count));
      return 5'($urandom_range(31));
   endfunction

   task automatic test_empty_list();
      send_request(ale_pkg::MODE_MIN, 5'd0, 32'h0);
      send_request(ale_pkg::MODE_READ, 5'd0, 32'h0);
      send_request(ale_pkg::MODE_DELETE, 5'd0, 32'd5);
      send_request(ale_pkg::MODE_COUNT, 5'd0, 32'h0);
      send_request(ale_pkg::MODE_INSERT, 5'd1, 32'h1234_5678);
      send_request(MODE_SPARE_LO, 5'd0, 32'h0);
   endtask

   task automatic test_edit_ops();
      send_request(ale_pkg::MODE_APPEND, 5'd0, 32'h8000_0000);
      send_request(ale_pkg::MODE_INSERT, 5'd0, 32'h7FFF_FFFF);
      send_request(ale_pkg::MODE_INSERT, 5'd2, 32'hFFFF_FFFF);
      send_request(ale_pkg::MODE_INSERT, 5'd1, 32'h0000_0000);
      send_request(ale_pkg::MODE_APPEND, 5'd31, 32'hFFFF_FFFF);
      send_request(ale_pkg::MODE_COUNT, 5'd0, 32'hFFFF_FFFF);
      send_request(ale_pkg::MODE_MIN, 5'd0, 32'h0);
      send_request(ale_pkg::MODE_READ, 5'd4, 32'h0);
      send_request(ale_pkg::MODE_READ, 5'd5, 32'h0);
      send_request(ale_pkg::MODE_READ, 5'd31, 32'hFFFF_FFFF);
      send_request(ale_pkg::MODE_DELETE, 5'd0, 32'hFFFF_FFFF);
      send_request(ale_pkg::MODE_DELETE, 5'd0, 32'd12345);
      send_request(MODE_SPARE_HI, 5'd31, $urandom());
      send_request(ale_pkg::MODE_INSERT, 5'd31, 32'd7);
      send_request(ale_pkg::MODE_MIN, 5'd0, 32'h0);
      drain_responses();
   endtask

   task automatic test_full_list();
      while (list_count < CAPACITY) begin
         if ($urandom_range(1)) begin
            send_request(ale_pkg::MODE_APPEND, 5'($urandom_range(31)), pick_value());
         end else begin
            send_request(ale_pkg::MODE_INSERT, 5'($urandom_range(list_count)), pick_value());
         end
      end
      send_request(ale_pkg::MODE_APPEND, 5'd0, pick_value());
      send_request(ale_pkg::MODE_INSERT, 5'd31, pick_value());
      send_request(ale_pkg::MODE_INSERT, 5'd0, pick_value());
      send_request(ale_pkg::MODE_READ, 5'd15, 32'h0);
      send_request(ale_pkg::MODE_READ, 5'd16, 32'h0);
      send_request(ale_pkg::MODE_MIN, 5'd0, 32'h0);
      send_request(ale_pkg::MODE_COUNT, 5'd0, list_words[$urandom_range(CAPACITY - 1)]);
      while (list_count > 0)
         send_request(ale_pkg::MODE_DELETE, 5'($urandom_range(31)),
                      list_words[$urandom_range(list_count - 1)]);
      send_request(ale_pkg::MODE_MIN, 5'd0, 32'h0);
      drain_responses();
   endtask

   task automatic test_random_traffic(int idle_pct, int stall_pct, int item_total);
      int         n;
      int         r;
      int         grow_pct;
      int         del_pct;
      logic [2:0] mode;
      logic [4:0] index;
      logic [WORD_BITS-1:0] value;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (n = 0; n < item_total; n++) begin
         if (list_count == CAPACITY) list_growing = 1'b0;
         if (list_count == 0) list_growing = 1'b1;
         grow_pct = list_growing ? 55 : 15;
         del_pct  = list_growing ? 15 : 55;
         r     = $urandom_range(99);
         index = pick_index();
         value = pick_value();
         if (r < grow_pct) begin
            mode = $urandom_range(1) ? ale_pkg::MODE_APPEND : ale_pkg::MODE_INSERT;
         end else if (r < grow_pct + del_pct) begin
            mode = ale_pkg::MODE_DELETE;
            if (list_count > 0 && $urandom_range(3) != 0)
               value = list_words[$urandom_range(list_count - 1)];
         end else if (r < 96) begin
            case ($urandom_range(2))
               0: mode = ale_pkg::MODE_COUNT;
               1: mode = ale_pkg::MODE_MIN;
               default: mode = ale_pkg::MODE_READ;
            endcase
         end else begin
            mode = $urandom_range(1) ? MODE_SPARE_LO : MODE_SPARE_HI;
         end
         send_request(mode, index, value);
         if (n == item_total / 2) drain_responses();
      end
      drain_responses();
   endtask

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_mode      = ale_pkg::MODE_APPEND;
      req_index     = '0;
      req_value     = '0;
      rsp_ready     = 1'b0;
      list_count    = 0;
      error_count   = 0;
      cycle_count   = 0;
      list_growing  = 1'b1;
      send_idle_pct = 36;
      rsp_stall_pct = 53;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_edit_ops();
      test_full_list();
      test_random_traffic(36, 53, 380);
      test_random_traffic(53, 36, 380);
      test_random_traffic(0, 0, 380);

      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, pending_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
